// ===== rtl/core/rect_sum_point_add_2d_tree_assert.svh =====
// assertion macros used by the rectangle sum tree back end
`ifndef RECT_SUM_POINT_ADD_2D_TREE_ASSERT_SVH
`define RECT_SUM_POINT_ADD_2D_TREE_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define RSP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
// consequent must hold in the same cycle as the antecedent
`define RSP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication failed");
`else
`define RSP_ASSERT(lbl, prop)
`define RSP_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/rsp2t_pkg.sv =====
// types and constants of the rectangle sum tree
`default_nettype none
package rsp2t_pkg;
	localparam int CoordW = 6;
	localparam int DeltaW = 32;
	localparam int SumW   = 48;

	localparam logic MODE_ADD   = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [1:0] {
		CMD_ADD,
		CMD_QUERY,
		CMD_ZERO
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                 kind;
		logic [CoordW-1:0]         row_lo;
		logic [CoordW-1:0]         row_hi;
		logic [CoordW-1:0]         col_lo;
		logic [CoordW-1:0]         col_hi;
		logic signed [DeltaW-1:0]  delta;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_READ,
		ST_USE
	} eng_state_t;
endpackage
`default_nettype wire

// ===== rtl/core/rsp2t_ram.sv =====
// generic single clock ram with registered read
`default_nettype none
module rsp2t_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/rsp2t_front.sv =====
// front end: takes requests, clips bounds, drops off-grid adds and classifies them
`default_nettype none
module rsp2t_front import rsp2t_pkg::*; #(
	parameter int ROWS = 64,
	parameter int COLS = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              mode,
	input  wire logic [CoordW-1:0] row_lo,
	input  wire logic [CoordW-1:0] row_hi,
	input  wire logic [CoordW-1:0] col_lo,
	input  wire logic [CoordW-1:0] col_hi,
	input  wire logic [DeltaW-1:0] delta,
	output logic                   cmd_valid,
	input  wire logic              cmd_ready,
	output cmd_t                   cmd
);
	localparam logic [CoordW-1:0] RowMax = CoordW'(ROWS - 1);
	localparam logic [CoordW-1:0] ColMax = CoordW'(COLS - 1);

	logic              valid_s1;
	cmd_t              cmd_s1;
	cmd_t              cls;
	logic              keep;
	logic [CoordW-1:0] rh_c;
	logic [CoordW-1:0] ch_c;

	// clip query bounds to the grid and sort the request
	always_comb begin
		rh_c = (32'(row_hi) >= ROWS) ? RowMax : row_hi;
		ch_c = (32'(col_hi) >= COLS) ? ColMax : col_hi;
		cls.row_lo = row_lo;
		cls.row_hi = rh_c;
		cls.col_lo = col_lo;
		cls.col_hi = ch_c;
		cls.delta  = delta;
		keep       = 1'b1;
		if (mode == MODE_QUERY) begin
			cls.kind = ((row_lo > rh_c) || (col_lo > ch_c)) ? CMD_ZERO : CMD_QUERY;
		end else begin
			cls.kind = CMD_ADD;
			keep     = (32'(row_lo) < ROWS) && (32'(col_lo) < COLS);
		end
	end

	assign in_ready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	// stage register toward the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= keep;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cls;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/rsp2t_queue.sv =====
// two entry command queue between front and back
`default_nettype none
module rsp2t_queue import rsp2t_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  cmd_t      in_cmd,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      out_cmd
);
	cmd_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_cmd   = ent_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= in_cmd;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/rsp2t_back.sv =====
// back end: walks the 2d index tree in ram for updates and queries
`default_nettype none
`include "rect_sum_point_add_2d_tree_assert.svh"
module rsp2t_back import rsp2t_pkg::*; #(
	parameter int ROWS = 64,
	parameter int COLS = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	output logic                 cmd_ready,
	input  cmd_t                 cmd,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [SumW-1:0]      out_sum
);
	localparam int AR    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int AC    = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int AW    = AR + AC;
	localparam int Depth = 2 ** AW;
	localparam int IW    = $clog2(ROWS) + 2;
	localparam int JW    = $clog2(COLS) + 2;
	localparam logic [IW-1:0] RowsI = IW'(ROWS);
	localparam logic [JW-1:0] ColsJ = JW'(COLS);

	eng_state_t        state_q;
	eng_state_t        state_d;
	cmd_t              cmd_q;
	logic [1:0]        corner_q;
	logic [IW-1:0]     i_q;
	logic [JW-1:0]     j_q;
	logic [JW-1:0]     j0_q;
	logic [SumW-1:0]   acc_q;
	logic [AW-1:0]     clr_q;
	logic              out_valid_q;
	logic [SumW-1:0]   out_sum_q;

	logic              is_upd;
	logic              last_corner;
	logic [IW-1:0]     row_start;
	logic [JW-1:0]     col_start;
	logic              start_empty;
	logic [IW-1:0]     i_low;
	logic [IW-1:0]     i_nx;
	logic              i_more;
	logic [JW-1:0]     j_low;
	logic [JW-1:0]     j_nx;
	logic              j_more;
	logic [AW-1:0]     node_addr;
	logic [SumW-1:0]   rdata;
	logic [SumW-1:0]   acc_nx;
	logic              skip_corner;
	logic              walk_done;

	logic              pop;
	logic              zero_load;
	logic              finish;
	logic [SumW-1:0]   finish_sum;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [SumW-1:0]   ram_wdata;
	logic              ram_re;

	// walk arithmetic: corner starts and index steps
	always_comb begin
		is_upd      = (cmd_q.kind == CMD_ADD);
		last_corner = (corner_q == 2'd3);
		if (is_upd) begin
			row_start = IW'(cmd_q.row_lo) + IW'(1);
			col_start = JW'(cmd_q.col_lo) + JW'(1);
		end else begin
			row_start = corner_q[0] ? IW'(cmd_q.row_lo) : IW'(cmd_q.row_hi) + IW'(1);
			col_start = corner_q[1] ? JW'(cmd_q.col_lo) : JW'(cmd_q.col_hi) + JW'(1);
		end
		start_empty = (row_start == '0) || (col_start == '0);
		i_low       = i_q & (~i_q + IW'(1));
		j_low       = j_q & (~j_q + JW'(1));
		i_nx        = is_upd ? i_q + i_low : i_q - i_low;
		j_nx        = is_upd ? j_q + j_low : j_q - j_low;
		i_more      = is_upd ? (i_nx <= RowsI) : (i_nx != '0);
		j_more      = is_upd ? (j_nx <= ColsJ) : (j_nx != '0);
		node_addr   = {AR'(i_q - IW'(1)), AC'(j_q - JW'(1))};
		acc_nx      = (corner_q[0] ^ corner_q[1]) ? acc_q - rdata : acc_q + rdata;
		skip_corner = !is_upd && start_empty;
		walk_done   = !i_more && !j_more;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid && !out_valid_q && (cmd.kind != CMD_ZERO)) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				if (skip_corner) begin
					state_d = last_corner ? ST_IDLE : ST_SETUP;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_USE;
			end
			ST_USE: begin
				if (!walk_done) begin
					state_d = ST_READ;
				end else if (is_upd || last_corner) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SETUP;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		pop        = 1'b0;
		zero_load  = 1'b0;
		finish     = 1'b0;
		finish_sum = acc_q;
		ram_we     = 1'b0;
		ram_waddr  = node_addr;
		ram_wdata  = rdata + SumW'(cmd_q.delta);
		ram_re     = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				pop       = cmd_valid && !out_valid_q;
				zero_load = pop && (cmd.kind == CMD_ZERO);
			end
			ST_SETUP: begin
				finish = skip_corner && last_corner;
			end
			ST_READ: begin
				ram_re = 1'b1;
			end
			ST_USE: begin
				ram_we     = is_upd;
				finish     = !is_upd && walk_done && last_corner;
				finish_sum = acc_nx;
			end
			default: begin
			end
		endcase
	end

	assign cmd_ready = pop;
	assign out_valid = out_valid_q;
	assign out_sum   = out_sum_q;

	// state, clear sweep and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (finish || zero_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// walk registers and accumulator
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q    <= cmd;
			corner_q <= 2'd0;
			acc_q    <= '0;
		end
		if (state_q == ST_SETUP) begin
			i_q  <= row_start;
			j_q  <= col_start;
			j0_q <= col_start;
			if (skip_corner) begin
				corner_q <= corner_q + 2'd1;
			end
		end
		if (state_q == ST_USE) begin
			if (!is_upd) begin
				acc_q <= acc_nx;
			end
			if (j_more) begin
				j_q <= j_nx;
			end else if (i_more) begin
				i_q <= i_nx;
				j_q <= j0_q;
			end else begin
				corner_q <= corner_q + 2'd1;
			end
		end
		if (zero_load) begin
			out_sum_q <= '0;
		end else if (finish) begin
			out_sum_q <= finish_sum;
		end
	end

	// node store
	rsp2t_ram #(
		.WIDTH(SumW),
		.DEPTH(Depth)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(node_addr),
		.rdata(rdata)
	);

	// checks
	`RSP_ASSERT_IMPL(a_no_result_overwrite, finish || zero_load, !out_valid_q)
	`RSP_ASSERT_IMPL(a_use_follows_read, state_q == ST_USE, $past(state_q) == ST_READ)
	`RSP_ASSERT_IMPL(a_write_only_update, ram_we && (state_q != ST_CLEAR), cmd_q.kind == CMD_ADD)
endmodule
`default_nettype wire

// ===== rtl/core/rect_sum_point_add_2d_tree.sv =====
// update: walks the tree nodes on its path, reading and then writing each node in turn
// query: up to 4 corner walks, each node read and then added into the sum
// empty rectangle queries skip the walk in the back end; front adds 1 stage
// the back end takes a new request only when idle with no result pending
// reset: a clearing pass over all 2^(clog2(ROWS)+clog2(COLS)) node addresses
// (4096 at 64x64) zeroes the node ram; requests queue in the front meanwhile
`default_nettype none
module rect_sum_point_add_2d_tree import rsp2t_pkg::*; #(
	parameter int ROWS = 64,
	parameter int COLS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// row_lo[5:0], row_hi[11:6], col_lo[17:12], col_hi[23:18], delta[55:24]
	input  wire logic [55:0] s_tdata,
	// mode[0]
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// rect_sum[47:0]
	output logic [47:0]      m_tdata
);
	logic cf_valid;
	logic cf_ready;
	cmd_t cf_cmd;
	logic cb_valid;
	logic cb_ready;
	cmd_t cb_cmd;

	// classify requests
	rsp2t_front #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.mode     (s_tuser),
		.row_lo   (s_tdata[5:0]),
		.row_hi   (s_tdata[11:6]),
		.col_lo   (s_tdata[17:12]),
		.col_hi   (s_tdata[23:18]),
		.delta    (s_tdata[55:24]),
		.cmd_valid(cf_valid),
		.cmd_ready(cf_ready),
		.cmd      (cf_cmd)
	);

	// decoupling queue
	rsp2t_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cf_valid),
		.in_ready (cf_ready),
		.in_cmd   (cf_cmd),
		.out_valid(cb_valid),
		.out_ready(cb_ready),
		.out_cmd  (cb_cmd)
	);

	// tree walker
	rsp2t_back #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cb_valid),
		.cmd_ready(cb_ready),
		.cmd      (cb_cmd),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_sum  (m_tdata)
	);
endmodule
`default_nettype wire

// ===== dv/tb_rect_sum_point_add_2d_tree.sv =====
// testbench for the two-dimensional rectangle sum tree: point adds, rectangle queries
`timescale 1ns / 1ps
`default_nettype none
module tb_rect_sum_point_add_2d_tree;
	import rsp2t_pkg::*;

	localparam int Rows = 64;
	localparam int Cols = 64;
	localparam int WatchLimit = 20000;
	localparam int SettleCycles = 300;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// row_lo[5:0], row_hi[11:6], col_lo[17:12], col_hi[23:18], delta[55:24]
	logic [55:0] s_tdata;
	// mode[0]
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// rect_sum[47:0]
	logic [47:0] m_tdata;

	// shadow copy of the grid cells, 48-bit wrapping
	logic [SumW-1:0] grid_cells [Rows][Cols];
	logic [SumW-1:0] pending_sums [$];

	int  mismatches;
	int  quiet_cycles;
	bit  idle_on;

	rect_sum_point_add_2d_tree #(.ROWS(Rows), .COLS(Cols)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// sum over an inclusive rectangle of the shadow grid
	function automatic logic [SumW-1:0] rect_total(int rlo, int rhi, int clo, int chi);
		logic [SumW-1:0] acc;
		acc = '0;
		for (int r = rlo; r <= rhi; r++)
			for (int c = clo; c <= chi; c++)
				acc = acc + grid_cells[r][c];
		return acc;
	endfunction

	// send one request and update the shadow grid when it is taken
	task automatic send_request(logic mode, logic [5:0] rlo, logic [5:0] rhi,
			logic [5:0] clo, logic [5:0] chi, logic signed [DeltaW-1:0] delta);
		bit taken;
		if (idle_on) begin
			while ($urandom_range(99) < 17) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {delta, chi, clo, rhi, rlo};
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		if (mode == MODE_ADD) begin
			grid_cells[rlo][clo] = grid_cells[rlo][clo] + SumW'(delta);
		end else if (rlo > rhi || clo > chi) begin
			pending_sums.push_back('0);
		end else begin
			pending_sums.push_back(rect_total(rlo, rhi, clo, chi));
		end
	endtask

	// hold off until every query answer is back and the adds have settled
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// extremes of every field: corners, full grid, single cells
	task automatic test_corners();
		send_request(MODE_ADD, 6'd0, 6'd0, 6'd0, 6'd0, 32'sh7fffffff);
		send_request(MODE_ADD, 6'd63, 6'd63, 6'd63, 6'd63, 32'sh80000000);
		send_request(MODE_ADD, 6'd0, 6'd63, 6'd63, 6'd0, -32'sd1);
		send_request(MODE_ADD, 6'd63, 6'd0, 6'd0, 6'd63, 32'sd1);
		send_request(MODE_ADD, 6'd21, 6'd42, 6'd42, 6'd21, 32'sh55555555);
		send_request(MODE_QUERY, 6'd0, 6'd63, 6'd0, 6'd63, '0);
		send_request(MODE_QUERY, 6'd0, 6'd0, 6'd0, 6'd0, '0);
		send_request(MODE_QUERY, 6'd63, 6'd63, 6'd63, 6'd63, '0);
		send_request(MODE_QUERY, 6'd0, 6'd0, 6'd63, 6'd63, '0);
		send_request(MODE_QUERY, 6'd63, 6'd63, 6'd0, 6'd0, '0);
		send_request(MODE_QUERY, 6'd1, 6'd62, 6'd1, 6'd62, '0);
		send_request(MODE_QUERY, 6'd21, 6'd21, 6'd0, 6'd63, '0);
	endtask

	// empty rectangles in rows, columns and both
	task automatic test_empty();
		send_request(MODE_QUERY, 6'd63, 6'd0, 6'd0, 6'd63, '0);
		send_request(MODE_QUERY, 6'd0, 6'd63, 6'd63, 6'd0, '0);
		send_request(MODE_QUERY, 6'd63, 6'd0, 6'd63, 6'd0, '0);
		send_request(MODE_QUERY, 6'd5, 6'd4, 6'd10, 6'd20, '0);
	endtask

	// large same-sign adds into one cell, sums well past 32 bits
	task automatic test_large_sums();
		for (int i = 0; i < 4; i++)
			send_request(MODE_ADD, 6'd32, 6'd0, 6'd31, 6'd0, 32'sh80000000);
		send_request(MODE_QUERY, 6'd0, 6'd63, 6'd0, 6'd63, '0);
		send_request(MODE_QUERY, 6'd32, 6'd32, 6'd31, 6'd31, '0);
		send_request(MODE_QUERY, 6'd31, 6'd33, 6'd30, 6'd32, '0);
	endtask

	// random adds and queries, mostly well-ordered rectangles
	task automatic test_random(int count);
		logic [5:0] a, b, c, d;
		logic       mode;
		for (int i = 0; i < count; i++) begin
			idle_on = !(i >= count / 3 && i < count / 2);
			if (i == count * 3 / 4)
				drain();
			mode = 1'($urandom_range(1));
			a = 6'($urandom);
			b = 6'($urandom);
			c = 6'($urandom);
			d = 6'($urandom);
			if (mode == MODE_QUERY && $urandom_range(9) != 0) begin
				if (a > b) {a, b} = {b, a};
				if (c > d) {c, d} = {d, c};
			end
			send_request(mode, a, b, c, d, $urandom);
		end
		idle_on = 1'b1;
	endtask

	// sink stalls
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else if (idle_on)
			m_tready <= ($urandom_range(99) >= 17);
		else
			m_tready <= 1'b1;
	end

	// answer check and watchdog, sampled away from the active edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_sums.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected answer %h", m_tdata);
				end else begin
					if (m_tdata !== pending_sums[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("sum mismatch: expected %h got %h",
								pending_sums[0], m_tdata);
					end
					void'(pending_sums.pop_front());
				end
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				quiet_cycles = 0;
			else if (s_tvalid || pending_sums.size() != 0)
				quiet_cycles++;
			if (quiet_cycles >= WatchLimit) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		mismatches   = 0;
		quiet_cycles = 0;
		idle_on      = 1'b1;
		for (int r = 0; r < Rows; r++)
			for (int c = 0; c < Cols; c++)
				grid_cells[r][c] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corners();
		test_empty();
		test_large_sums();
		test_random(1380);
		drain();
		if (mismatches == 0 && pending_sums.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
`default_nettype wire
